[rtl/rdc_pkg.sv]
// Shared constants, types and helpers for the radix digit converter.
package rdc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 32;
  localparam int IN_WIDTH    = 32;
  localparam int BASE_WIDTH  = 6;
  localparam int DIGIT_WIDTH = 6;
  localparam int CHAR_WIDTH  = 7;
  localparam int BITCNT_W    = $clog2(VALUE_WIDTH);
  localparam int ADDR_W      = $clog2(MAX_DIGITS);
  localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);

  localparam logic [BASE_WIDTH-1:0]  BASE_RESET   = BASE_WIDTH'(10);
  localparam logic [BASE_WIDTH-1:0]  BASE_MIN     = BASE_WIDTH'(2);
  localparam logic [BASE_WIDTH-1:0]  BASE_MAX     = BASE_WIDTH'(36);
  localparam logic [DIGIT_WIDTH-1:0] DECIMAL_LIM  = DIGIT_WIDTH'(10);
  localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO   = CHAR_WIDTH'(48);
  localparam logic [CHAR_WIDTH-1:0]  ASCII_LETTER = CHAR_WIDTH'(55);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // Divider status toward the controller
  typedef struct packed {
    logic                   done;
    logic                   quot_nz;
    logic [DIGIT_WIDTH-1:0] rem;
  } div_status_t;

  function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
    if (d < DECIMAL_LIM) begin
      return CHAR_WIDTH'(d) + ASCII_ZERO;
    end
    return CHAR_WIDTH'(d) + ASCII_LETTER;
  endfunction

  function automatic logic [BASE_WIDTH-1:0] sat_base(input logic [BASE_WIDTH-1:0] b);
    if (b < BASE_MIN) begin
      return BASE_MIN;
    end
    if (b > BASE_MAX) begin
      return BASE_MAX;
    end
    return b;
  endfunction

endpackage

[rtl/radix_digit_converter_core.sv]
// Radix digit converter: value to base-k ASCII digit string, MSD first.
// Digits are produced LSD first by a bit-serial divider and stored, then read
//   back and emitted MSD first, one character at a time.
// A new value is taken only once the last character of the previous one has
//   been emitted; in_stall stays high while the block is busy.
// Reset (synchronous, rst_n low): controller idle, output empty, base = 10.
module radix_digit_converter_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration: base register
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rdc_pkg::BASE_WIDTH-1:0]     cfg_base,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [rdc_pkg::IN_WIDTH-1:0]       in_value,
  // result items
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rdc_pkg::CHAR_WIDTH-1:0]     out_char_code,
  output logic                               out_last
);
  import rdc_pkg::*;

  state_t                 state_r, state_nxt;
  logic [BASE_WIDTH-1:0]  base_r;
  logic [BASE_WIDTH-1:0]  eff_base;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0]      idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_WIDTH-1:0]  out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  // divider hookup
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [VALUE_WIDTH-1:0] div_quot;
  div_status_t            div_st;

  // digit store hookup
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [DIGIT_WIDTH-1:0] ram_wdata;
  logic [DIGIT_WIDTH-1:0] ram_rdata;

  logic                   in_acc;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] in_val_w;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_val_w  = VALUE_WIDTH'(in_value);
  assign eff_base  = sat_base(base_r);

  // base register; only written while idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      base_r <= cfg_base;
    end
  end

  rdc_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_base),
    .quotient (div_quot),
    .status   (div_st)
  );

  rdc_digit_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload needs no reset
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    div_start     = 1'b0;
    div_dividend  = div_quot;
    ram_we        = 1'b0;
    ram_waddr     = count_r[ADDR_W-1:0];
    ram_wdata     = div_st.rem;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_val_w == '0) begin
            // zero value: single '0' digit
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '0;
            count_nxt = COUNT_W'(1);
            idx_nxt   = '0;
            state_nxt = ST_EMIT_RD;
          end else begin
            div_start    = 1'b1;
            div_dividend = in_val_w;
            count_nxt    = '0;
            state_nxt    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          // remainder is the next digit, LSD first
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          if (div_st.quot_nz && (count_r < COUNT_W'(MAX_DIGITS - 1))) begin
            div_start = 1'b1;
          end else begin
            idx_nxt   = count_r[ADDR_W-1:0];
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_RD: begin
        // read of idx_r lands next cycle
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_ascii(ram_rdata);
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

[rtl/rdc_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle by a 6-bit radix.
module rdc_divider (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rdc_pkg::VALUE_WIDTH-1:0]     dividend,
  input  logic [rdc_pkg::BASE_WIDTH-1:0]      divisor,
  output logic [rdc_pkg::VALUE_WIDTH-1:0]     quotient,
  output rdc_pkg::div_status_t                status
);
  import rdc_pkg::*;

  logic [VALUE_WIDTH-1:0] q_r;
  logic [DIGIT_WIDTH-1:0] rem_r, rem_nxt;
  logic [BITCNT_W-1:0]    cnt_r;
  logic                   busy_r, done_r, nz_r;
  logic [DIGIT_WIDTH:0]   trial;
  logic                   ge;

  always_comb begin
    trial   = {rem_r, q_r[VALUE_WIDTH-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = ge ? DIGIT_WIDTH'(trial - {1'b0, divisor}) : trial[DIGIT_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      nz_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        nz_r   <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        nz_r  <= nz_r | ge;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == BITCNT_W'(VALUE_WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[VALUE_WIDTH-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient       = q_r;
  assign status.done    = done_r;
  assign status.quot_nz = nz_r;
  assign status.rem     = rem_r;

endmodule

[rtl/rdc_digit_ram.sv]
// Digit store: one write port, one registered read port.
module rdc_digit_ram (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [rdc_pkg::ADDR_W-1:0]      wr_addr,
  input  logic [rdc_pkg::DIGIT_WIDTH-1:0] wr_data,
  input  logic [rdc_pkg::ADDR_W-1:0]      rd_addr,
  output logic [rdc_pkg::DIGIT_WIDTH-1:0] rd_data
);
  import rdc_pkg::*;

  logic [DIGIT_WIDTH-1:0] mem [MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[tb/sv/tb_radix_digit_converter_core.sv]
// Self-checking testbench for radix_digit_converter_core: base-k digit strings against a predictor.
`timescale 1ns / 100ps

module tb_radix_digit_converter_core;

  import rdc_pkg::*;

  // Predictor constants, kept apart from the RTL package on purpose
  localparam int unsigned DIGIT_ASCII_BASE  = 48;  // '0'
  localparam int unsigned LETTER_ASCII_BASE = 55;  // 'A' - 10
  localparam int unsigned DECIMAL_DIGITS    = 10;
  localparam int unsigned RADIX_FLOOR       = 2;
  localparam int unsigned RADIX_CEIL        = 36;
  localparam int unsigned DIGIT_LIMIT       = 32;

  localparam int unsigned RANDOM_ITEMS  = 336;
  localparam int unsigned IDLE_PERCENT  = 16;
  localparam int unsigned HOLD_CYCLES   = 3000;
  localparam int unsigned HOLD_AT_ITEM  = 200;
  localparam int unsigned SETTLE_CYCLES = 80;

  // One emitted character as the block should present it
  typedef struct packed {
    logic [CHAR_WIDTH-1:0] char_code;
    logic                  last;
  } glyph_t;

  // Tracks the base register and the characters still owed by the block
  class digit_string_book;
    logic [BASE_WIDTH-1:0] radix_reg;
    glyph_t                owed_glyphs[$];
    int unsigned           errors;

    function new();
      radix_reg = BASE_WIDTH'(10);
      errors    = 0;
    endfunction

    function void set_radix(logic [BASE_WIDTH-1:0] b);
      radix_reg = b;
    endfunction

    function int unsigned owed();
      return owed_glyphs.size();
    endfunction

    // Accepted value: divide it down and queue its characters, MSD first
    function void note_value(logic [IN_WIDTH-1:0] v);
      logic [31:0]          k;
      logic [31:0]          quot;
      logic [5:0]           digits[$];
      glyph_t               g;
      int                   j;
      k = {26'd0, radix_reg};
      if (k < RADIX_FLOOR) k = RADIX_FLOOR;
      if (k > RADIX_CEIL) k = RADIX_CEIL;
      quot = v;
      if (quot == 0) begin
        digits.push_back(6'd0);
      end else begin
        while (quot != 0 && digits.size() < DIGIT_LIMIT) begin
          digits.push_back(6'(quot % k));
          quot = quot / k;
        end
      end
      for (j = digits.size() - 1; j >= 0; j--) begin
        if (digits[j] < DECIMAL_DIGITS)
          g.char_code = CHAR_WIDTH'(digits[j] + DIGIT_ASCII_BASE);
        else
          g.char_code = CHAR_WIDTH'(digits[j] + LETTER_ASCII_BASE);
        g.last = (j == 0);
        owed_glyphs.push_back(g);
      end
    endfunction

    // Accepted result: compare with the oldest owed character
    function void check_char(logic [CHAR_WIDTH-1:0] c, logic l);
      glyph_t g;
      if (owed_glyphs.size() == 0) begin
        $display("%0t: unexpected item char_code=%0d last=%0b", $time, c, l);
        errors++;
        return;
      end
      g = owed_glyphs.pop_front();
      if (c !== g.char_code) begin
        $display("%0t: char_code mismatch expected %0d actual %0d", $time, g.char_code, c);
        errors++;
      end
      if (l !== g.last) begin
        $display("%0t: last mismatch expected %0b actual %0b", $time, g.last, l);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [BASE_WIDTH-1:0] cfg_base;
  logic                  in_valid;
  logic                  in_stall;
  logic [IN_WIDTH-1:0]   in_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [CHAR_WIDTH-1:0] out_char_code;
  logic                  out_last;

  digit_string_book book;
  int unsigned      items_sent;

  radix_digit_converter_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_base     (cfg_base),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Known values on every input from time zero
  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_base      = '0;
    in_valid      = 1'b0;
    in_value      = '0;
    out_stall     = 1'b0;
    items_sent    = 0;
    book          = new();
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off
  // counted here so the sender keeps offering items and the block backs up.
  initial begin : result_sink
    int unsigned hold_left;
    bit          hold_done;
    bit          calm;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      calm = (items_sent >= 100 && items_sent < 160);
      if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PERCENT);
      end
    end
  end

  // Sample at the rising edge; an item moves when valid is high and stall low
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      book.check_char(out_char_code, out_last);
    end
  end

  // Offer one value; called at a falling edge, returns at a falling edge.
  // Valid stays high on return so back-to-back items never glitch it.
  task automatic offer_value(input logic [IN_WIDTH-1:0] v);
    bit calm;
    calm = (items_sent >= 250 && items_sent < 310);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      in_value <= $urandom();
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    book.note_value(v);
    items_sent++;
    @(negedge clk);
  endtask

  // Stop sending and let every owed character come out, plus a settle gap
  task automatic drain_results();
    in_valid <= 1'b0;
    while (book.owed() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Base register write, only once the block has gone idle
  task automatic load_radix(input logic [BASE_WIDTH-1:0] b);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_base  <= b;
    do @(posedge clk); while (!cfg_ready);
    book.set_radix(b);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_base  <= BASE_WIDTH'($urandom());
  endtask

  // Mostly short values so base 2 does not dominate run time
  function automatic logic [IN_WIDTH-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return '0;
    if (sel < 14) return '1;
    if (sel < 30) return $urandom();
    if (sel < 50) return $urandom_range(0, 100);
    return $urandom() >> $urandom_range(4, 31);
  endfunction

  function automatic logic [BASE_WIDTH-1:0] pick_radix();
    if ($urandom_range(0, 99) < 20) return BASE_WIDTH'($urandom_range(0, 63));
    return BASE_WIDTH'($urandom_range(2, 36));
  endfunction

  initial begin : stimulus
    int unsigned target;
    int unsigned batch;
    int unsigned i;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset base (decimal): zero value, single digits, rollover to two digits,
    // top bit, all ones
    offer_value(32'd0);
    offer_value(32'd1);
    offer_value(32'd9);
    offer_value(32'd10);
    offer_value(32'd99);
    offer_value(32'hFFFF_FFFF);
    offer_value(32'h8000_0000);

    // Binary: longest strings
    load_radix(6'd2);
    offer_value(32'd0);
    offer_value(32'd1);
    offer_value(32'd2);
    offer_value(32'hFFFF_FFFF);
    offer_value(32'h8000_0000);
    offer_value(32'hAAAA_AAAA);

    // Base 36: highest letter 'Z' and its rollover
    load_radix(6'd36);
    offer_value(32'd35);
    offer_value(32'd36);
    offer_value(32'd1295);
    offer_value(32'hFFFF_FFFF);
    offer_value(32'd0);

    // Out-of-range bases saturate: all-zero and below two act as binary,
    // all-ones and above 36 act as base 36
    load_radix(6'd0);
    offer_value(32'd5);
    offer_value(32'h5555_5555);
    load_radix(6'd63);
    offer_value(32'hFFFF_FFFF);
    offer_value(32'd10);
    load_radix(6'd1);
    offer_value(32'd6);
    load_radix(6'd37);
    offer_value(32'd71);

    // Random phases, each under a fresh base
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      load_radix(pick_radix());
      batch = $urandom_range(20, 50);
      for (i = 0; i < batch && items_sent < target; i++) begin
        offer_value(pick_value());
      end
    end

    drain_results();
    if (book.errors == 0 && book.owed() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin : watchdog
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
